// ----- hdl/lodd_pkg.sv -----
// Package for the lock-order deadlock detector: request and result types,
// slot counts, function codes and controller states. No dependencies.
package lodd_pkg;

    localparam int THREAD_SLOTS = 16;
    localparam int LOCK_SLOTS   = 16;
    localparam int TAG_W        = 48;
    localparam int TIDX_W       = $clog2(THREAD_SLOTS);
    localparam int LIDX_W       = $clog2(LOCK_SLOTS);
    localparam int TCNT_W       = $clog2(THREAD_SLOTS + 1);
    localparam int LCNT_W       = $clog2(LOCK_SLOTS + 1);

    typedef enum logic [1:0] {
        FUNC_LOCK   = 2'd0,
        FUNC_UNLOCK = 2'd1,
        FUNC_EXIT   = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_THREAD_FULL = 2'd1,
        ST_LOCK_FULL   = 2'd2
    } status_t;

    typedef struct packed {
        logic [1:0]       func;
        logic [TAG_W-1:0] thread_id;
        logic [TAG_W-1:0] lock_address;
    } req_t;

    typedef struct packed {
        logic       deadlock;
        logic [1:0] status;
    } rsp_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TSEARCH,
        S_LSEARCH,
        S_ACQUIRE,
        S_PEEL,
        S_RELEASE,
        S_EXIT,
        S_RESP
    } state_t;

    // Commands from controller to datapath.
    typedef struct packed {
        logic load_req;
        logic clr_search;
        logic t_step;
        logic l_step;
        logic acquire;
        logic t_claim;
        logic peel_init;
        logic peel_step;
        logic unlock;
        logic thread_exit;
        logic [1:0] set_status;
        logic status_we;
    } cmd_t;

    // Status from datapath to controller.
    typedef struct packed {
        logic [1:0] func;
        logic t_done;
        logic t_found;
        logic t_free;
        logic l_done;
        logic l_found;
        logic l_free;
        logic peel_done;
    } sts_t;

endpackage

// ----- hdl/lodd_datapath.sv -----
// Datapath of the lock-order deadlock detector: tag tables, held sets,
// edge rows, sequential tag searches and the peel-based cycle check.
// Depends on lodd_pkg.
module lodd_datapath
    import lodd_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  req_t req,
    input  cmd_t cmd,
    output sts_t sts,
    output rsp_t rsp
);

    logic [THREAD_SLOTS-1:0] tvalid_reg;
    logic [TAG_W-1:0]        ttag_mem [THREAD_SLOTS];
    logic [LOCK_SLOTS-1:0]   held_reg [THREAD_SLOTS];
    logic [LOCK_SLOTS-1:0]   lvalid_reg;
    logic [TAG_W-1:0]        ltag_mem [LOCK_SLOTS];
    logic [LOCK_SLOTS-1:0]   edge_reg [LOCK_SLOTS];

    req_t              req_reg;
    logic [TCNT_W-1:0] tcnt_reg;
    logic [LCNT_W-1:0] lcnt_reg;
    logic              tfound_reg, tfree_reg, lfound_reg, lfree_reg;
    logic [TIDX_W-1:0] tidx_reg, tfidx_reg;
    logic [LIDX_W-1:0] lidx_reg, lfidx_reg;
    logic [LOCK_SLOTS-1:0] rem_reg;
    logic              changed_reg;
    logic [LCNT_W-1:0] pcnt_reg;
    rsp_t              rsp_reg;

    logic [TIDX_W-1:0] tptr;
    logic [LIDX_W-1:0] lptr, pptr;
    logic              t_hit, l_hit;
    logic [TIDX_W-1:0] tslot;
    logic [LIDX_W-1:0] lslot;

    assign tptr  = tcnt_reg[TIDX_W-1:0];
    assign lptr  = lcnt_reg[LIDX_W-1:0];
    assign pptr  = pcnt_reg[LIDX_W-1:0];
    assign t_hit = tvalid_reg[tptr] && (ttag_mem[tptr] == req_reg.thread_id);
    assign l_hit = lvalid_reg[lptr] && (ltag_mem[lptr] == req_reg.lock_address);
    assign tslot = tfound_reg ? tidx_reg : tfidx_reg;
    assign lslot = lfound_reg ? lidx_reg : lfidx_reg;

    assign sts.func      = req_reg.func;
    assign sts.t_done    = (tcnt_reg == TCNT_W'(THREAD_SLOTS)) || tfound_reg;
    assign sts.t_found   = tfound_reg;
    assign sts.t_free    = tfree_reg;
    assign sts.l_done    = (lcnt_reg == LCNT_W'(LOCK_SLOTS)) || lfound_reg;
    assign sts.l_found   = lfound_reg;
    assign sts.l_free    = lfree_reg;
    assign sts.peel_done = (pcnt_reg == LCNT_W'(LOCK_SLOTS)) && !changed_reg;
    assign rsp           = rsp_reg;

    // Request capture, search scan and peel bookkeeping.
    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            req_reg <= req;
        end
        if (cmd.clr_search) begin
            tcnt_reg   <= '0;
            lcnt_reg   <= '0;
            tfound_reg <= 1'b0;
            tfree_reg  <= 1'b0;
            lfound_reg <= 1'b0;
            lfree_reg  <= 1'b0;
        end
        // One thread slot is compared per cycle; the first free slot is noted.
        if (cmd.t_step) begin
            if (t_hit) begin
                tfound_reg <= 1'b1;
                tidx_reg   <= tptr;
            end else begin
                if (!tvalid_reg[tptr] && !tfree_reg) begin
                    tfree_reg <= 1'b1;
                    tfidx_reg <= tptr;
                end
                tcnt_reg <= tcnt_reg + 1'b1;
            end
        end
        if (cmd.l_step) begin
            if (l_hit) begin
                lfound_reg <= 1'b1;
                lidx_reg   <= lptr;
            end else begin
                if (!lvalid_reg[lptr] && !lfree_reg) begin
                    lfree_reg <= 1'b1;
                    lfidx_reg <= lptr;
                end
                lcnt_reg <= lcnt_reg + 1'b1;
            end
        end
        // The peel pass revisits nodes until a full sweep removes none.
        if (cmd.peel_init) begin
            pcnt_reg    <= '0;
            changed_reg <= 1'b0;
        end else if (cmd.peel_step) begin
            if (pcnt_reg == LCNT_W'(LOCK_SLOTS)) begin
                pcnt_reg    <= '0;
                changed_reg <= 1'b0;
            end else begin
                pcnt_reg <= pcnt_reg + 1'b1;
                if (rem_reg[pptr] && ((edge_reg[pptr] & rem_reg) == '0)) begin
                    changed_reg <= 1'b1;
                end
            end
        end
        if (cmd.status_we) begin
            rsp_reg.status   <= cmd.set_status;
            rsp_reg.deadlock <= 1'b0;
        end
        if (cmd.peel_step && sts.peel_done) begin
            rsp_reg.deadlock <= (rem_reg != '0);
        end
    end

    // Tag stores carry no reset; they are read only in valid slots.
    always_ff @(posedge aclk) begin
        if ((cmd.acquire || cmd.t_claim) && !tfound_reg) begin
            ttag_mem[tslot] <= req_reg.thread_id;
        end
        if (cmd.acquire && !lfound_reg) begin
            ltag_mem[lslot] <= req_reg.lock_address;
        end
    end

    // Valid bits, held sets, edges and the remaining set.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tvalid_reg <= '0;
            lvalid_reg <= '0;
            for (int i = 0; i < THREAD_SLOTS; i++) begin
                held_reg[i] <= '0;
            end
            for (int i = 0; i < LOCK_SLOTS; i++) begin
                edge_reg[i] <= '0;
            end
        end else begin
            if (cmd.acquire) begin
                tvalid_reg[tslot] <= 1'b1;
                lvalid_reg[lslot] <= 1'b1;
                for (int h = 0; h < LOCK_SLOTS; h++) begin
                    if (h == int'(lslot)) begin
                        if (!lfound_reg) begin
                            edge_reg[h] <= '0;
                        end
                    end else if (tfound_reg && held_reg[tslot][h]) begin
                        edge_reg[h][lslot] <= 1'b1;
                    end
                end
                if (tfound_reg) begin
                    held_reg[tslot][lslot] <= 1'b1;
                end else begin
                    held_reg[tslot] <= LOCK_SLOTS'(1) << lslot;
                end
            end
            // A new thread keeps its slot even when the lock table is full.
            if (cmd.t_claim && !tfound_reg) begin
                tvalid_reg[tslot] <= 1'b1;
                held_reg[tslot]   <= '0;
            end
            if (cmd.unlock) begin
                lvalid_reg[lidx_reg] <= 1'b0;
                for (int i = 0; i < THREAD_SLOTS; i++) begin
                    held_reg[i][lidx_reg] <= 1'b0;
                end
                for (int i = 0; i < LOCK_SLOTS; i++) begin
                    if (i == int'(lidx_reg)) begin
                        edge_reg[i] <= '0;
                    end else begin
                        edge_reg[i][lidx_reg] <= 1'b0;
                    end
                end
            end
            if (cmd.thread_exit) begin
                tvalid_reg[tidx_reg] <= 1'b0;
                held_reg[tidx_reg]   <= '0;
            end
        end
    end

    // The remaining set starts from the valid nodes, including a node taken
    // by an acquire at the same edge.
    always_ff @(posedge aclk) begin
        if (cmd.peel_init) begin
            if (cmd.acquire) begin
                rem_reg <= lvalid_reg | (LOCK_SLOTS'(1) << lslot);
            end else begin
                rem_reg <= lvalid_reg;
            end
        end else if (cmd.peel_step && (pcnt_reg != LCNT_W'(LOCK_SLOTS))) begin
            if (rem_reg[pptr] && ((edge_reg[pptr] & rem_reg) == '0)) begin
                rem_reg[pptr] <= 1'b0;
            end
        end
    end

endmodule

// ----- hdl/lodd_ctrl.sv -----
// Controller of the lock-order deadlock detector: sequences searches,
// table updates, the cycle check and the result handshake.
// Depends on lodd_pkg.
module lodd_ctrl
    import lodd_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    output logic m_valid,
    input  logic m_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_TSEARCH;
                end
            end
            S_TSEARCH: begin
                if (sts.t_done) begin
                    case (sts.func)
                        FUNC_LOCK: begin
                            state_next = (sts.t_found || sts.t_free) ? S_LSEARCH : S_PEEL;
                        end
                        FUNC_UNLOCK: state_next = S_LSEARCH;
                        FUNC_EXIT:   state_next = S_EXIT;
                        default:     state_next = S_RESP;
                    endcase
                end
            end
            S_LSEARCH: begin
                if (sts.l_done) begin
                    if (sts.func == FUNC_UNLOCK) begin
                        state_next = S_RELEASE;
                    end else if (sts.l_found || sts.l_free) begin
                        state_next = S_ACQUIRE;
                    end else begin
                        state_next = S_PEEL;
                    end
                end
            end
            S_ACQUIRE: state_next = S_PEEL;
            S_PEEL: begin
                if (sts.peel_done) begin
                    state_next = S_RESP;
                end
            end
            S_RELEASE: state_next = S_RESP;
            S_EXIT:    state_next = S_RESP;
            S_RESP: begin
                if (m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        cmd        = '0;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready        = 1'b1;
                cmd.load_req   = s_valid;
                cmd.clr_search = 1'b1;
                cmd.status_we  = 1'b1;
                cmd.set_status = ST_OK;
            end
            S_TSEARCH: begin
                cmd.t_step = !sts.t_done;
                if (sts.t_done && (sts.func == FUNC_LOCK) && !sts.t_found
                        && !sts.t_free) begin
                    cmd.status_we  = 1'b1;
                    cmd.set_status = ST_THREAD_FULL;
                    cmd.peel_init  = 1'b1;
                end
            end
            S_LSEARCH: begin
                cmd.l_step = !sts.l_done;
                if (sts.l_done && (sts.func == FUNC_LOCK) && !sts.l_found
                        && !sts.l_free) begin
                    cmd.status_we  = 1'b1;
                    cmd.set_status = ST_LOCK_FULL;
                    cmd.peel_init  = 1'b1;
                    cmd.t_claim    = 1'b1;
                end
            end
            // The peel pass starts together with the table update.
            S_ACQUIRE: begin
                cmd.acquire   = 1'b1;
                cmd.peel_init = 1'b1;
            end
            S_PEEL:    cmd.peel_step = 1'b1;
            S_RELEASE: cmd.unlock = sts.l_found;
            S_EXIT:    cmd.thread_exit = sts.t_found;
            S_RESP:    m_valid = 1'b1;
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ----- hdl/lock_order_deadlock_detector.sv -----
// Top level of the lock-order deadlock detector.
// Depends on lodd_pkg, lodd_ctrl and lodd_datapath.
//
//   channel  | ports                | payload
//   request  | s_valid / s_ready    | s_req  (func, thread_id, lock_address)
//   result   | m_valid / m_ready    | m_rsp  (deadlock, status)
//
// One request at a time. A lock request is captured, then the thread tag search
// and the lock tag search each compare one slot per cycle and end in a decision
// step, the tables are updated, then a cycle check sweeps the 16 lock nodes one
// per cycle plus a wrap step until a sweep peels none, and the result is given.
// Reset clears all valid bits, held sets and edges at once; no clearing pass.
// The result is held until m_ready; the next request is taken after that.
module lock_order_deadlock_detector
    import lodd_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  req_t s_req,
    output logic m_valid,
    input  logic m_ready,
    output rsp_t m_rsp
);

    cmd_t cmd;
    sts_t sts;

    lodd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    lodd_datapath u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (s_req),
        .cmd     (cmd),
        .sts     (sts),
        .rsp     (m_rsp)
    );

endmodule
